/* rtl/ales_pkg.sv */
// Package for the audio level envelope sampler: payload structs, the internal
// command struct, the operation enum and the fixed field widths and codes.
// No dependencies.
package ales_pkg;

   // Field widths fixed by the interface
   localparam int ENTITY_W = 8;
   localparam int SAMPLE_W = 32;
   localparam int LEVEL_W  = 8;
   localparam int SKIP_W   = 7;
   localparam int FMT_W    = 2;
   localparam int MODE_W   = 2;

   // Largest magnitude of a signed 8-bit level
   localparam int LEVEL_SPAN = 128;

   // Command queue between front and back end
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Mode codes
   localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_INIT   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLOSE  = 2'd2;

   // Sample format codes
   localparam logic [FMT_W-1:0] FMT_U8  = 2'd0;
   localparam logic [FMT_W-1:0] FMT_S16 = 2'd1;
   localparam logic [FMT_W-1:0] FMT_F32 = 2'd2;

   // Level clamp values, two's complement
   localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'h7F;
   localparam logic [LEVEL_W-1:0] LEVEL_MIN = 8'h80;

   // Skip after a pick: base plus low five bits of the level
   localparam logic [SKIP_W-1:0] SKIP_BASE = 7'd79;

   // Float32 exponent thresholds
   localparam logic [7:0] EXP_SPECIAL    = 8'hFF;
   localparam logic [7:0] EXP_CLAMP      = 8'd127;
   localparam logic [7:0] EXP_MIN        = 8'd120;
   localparam logic [7:0] EXP_SHIFT_BASE = 8'd143;

   // Classified operation carried from front to back end
   typedef enum logic [2:0] {
      OP_SAMPLE,
      OP_INIT,
      OP_CLOSE,
      OP_HOLD,
      OP_IGNORE
   } op_type;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [ENTITY_W-1:0] entity;
      logic [SAMPLE_W-1:0] sample_bits;
      logic                first_of_scan;
   } req_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] mouth_level;
      logic               level_updated;
   } rsp_type;

   typedef struct packed {
      op_type              op;
      logic [ENTITY_W-1:0] entity;
      logic                first;
      logic [LEVEL_W-1:0]  mag;
      logic [SKIP_W-1:0]   skip;
   } cmd_type;

endpackage

/* rtl/ales_front.sv */
// Front end: classifies each incoming item and converts its sample to a level.
// Produces a queue command (magnitude and skip length precomputed).
// Depends on ales_pkg.
module ales_front #(
   parameter int ENTITY_COUNT = 256
) (
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  ales_pkg::req_type             req_data,
   input  logic [ales_pkg::FMT_W-1:0]    sample_format,
   output logic                          q_push,
   output ales_pkg::cmd_type             q_cmd
);
   import ales_pkg::*;

   localparam int ENT_DEPTH = (ENTITY_COUNT < (1 << ENTITY_W)) ? ENTITY_COUNT : (1 << ENTITY_W);
   localparam logic [ENTITY_W:0] ENT_LIMIT = (ENTITY_W + 1)'(ENT_DEPTH);

   logic [7:0]         flt_exp;
   logic [22:0]        flt_man;
   logic               flt_neg;
   logic [4:0]         flt_shift;
   logic [23:0]        flt_sig;
   logic [LEVEL_W-1:0] flt_mag;
   logic [LEVEL_W-1:0] flt_lvl;
   logic [LEVEL_W-1:0] lvl;
   logic [LEVEL_W-1:0] mag;
   logic               in_range;

   // Float32 to level: scale by 128, clamp, truncate toward zero
   always_comb begin
      flt_exp   = req_data.sample_bits[30:23];
      flt_man   = req_data.sample_bits[22:0];
      flt_neg   = req_data.sample_bits[31];
      flt_shift = 5'(EXP_SHIFT_BASE - flt_exp);
      flt_sig   = {1'b1, flt_man} >> flt_shift;
      flt_mag   = flt_sig[LEVEL_W-1:0];
      if (flt_exp == EXP_SPECIAL && flt_man != '0) begin
         flt_lvl = '0;                 // NaN
      end else if (flt_exp >= EXP_CLAMP) begin
         flt_lvl = flt_neg ? LEVEL_MIN : LEVEL_MAX;
      end else if (flt_exp < EXP_MIN) begin
         flt_lvl = '0;                 // below one step
      end else begin
         flt_lvl = flt_neg ? LEVEL_W'(8'd0 - flt_mag) : flt_mag;
      end
   end

   // Format select
   always_comb begin
      case (sample_format)
         FMT_U8: begin
            lvl = {~req_data.sample_bits[7], req_data.sample_bits[6:0]};
         end
         FMT_S16: begin
            lvl = req_data.sample_bits[15:8];
         end
         FMT_F32: begin
            lvl = flt_lvl;
         end
         default: begin
            lvl = '0;
         end
      endcase
   end

   assign mag      = lvl[LEVEL_W-1] ? LEVEL_W'(8'd0 - lvl) : lvl;
   assign in_range = {1'b0, req_data.entity} < ENT_LIMIT;

   // Classify and build the command
   always_comb begin
      q_cmd.entity = req_data.entity;
      q_cmd.first  = req_data.first_of_scan;
      q_cmd.mag    = mag;
      q_cmd.skip   = SKIP_BASE + {2'b00, lvl[4:0]};
      if (!in_range) begin
         q_cmd.op = OP_IGNORE;
      end else begin
         case (req_data.mode)
            MODE_SAMPLE: q_cmd.op = OP_SAMPLE;
            MODE_INIT:   q_cmd.op = OP_INIT;
            MODE_CLOSE:  q_cmd.op = OP_CLOSE;
            default:     q_cmd.op = OP_HOLD;
         endcase
      end
   end

   assign q_push = req_valid && !req_stall;

endmodule

/* rtl/ales_queue.sv */
// Short command queue between the front and back end.
// Register slots with read and write pointers. Depends on ales_pkg.
module ales_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ales_pkg::cmd_type  push_data,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output ales_pkg::cmd_type  head_data
);
   import ales_pkg::*;

   cmd_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Slot storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full       = count_ff == (QPTR_W + 1)'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_data  = slot_ff[rd_ptr_ff];

endmodule

/* rtl/ales_back.sv */
// Back end: per-entity read-modify-write of sum, pick count and level, shared
// scan state, and the divide-by-AVG_PICKS output stage. Depends on ales_pkg.
module ales_back #(
   parameter int AVG_PICKS    = 10,
   parameter int ENTITY_COUNT = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  ales_pkg::cmd_type  q_data,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output ales_pkg::rsp_type  rsp_data
);
   import ales_pkg::*;

   localparam int ENT_DEPTH = (ENTITY_COUNT < (1 << ENTITY_W)) ? ENTITY_COUNT : (1 << ENTITY_W);
   localparam int IDX_W     = (ENT_DEPTH > 1) ? $clog2(ENT_DEPTH) : 1;
   localparam int SUM_W     = $clog2(AVG_PICKS * LEVEL_SPAN + 1);
   localparam int CNT_W     = $clog2(AVG_PICKS + 1);
   localparam int ENTRY_W   = 2 * SUM_W + CNT_W;
   localparam int PROD_W    = 2 * SUM_W + 1;
   // Exact reciprocal: floor(n / D) = (n * ceil(2^(N+L) / D)) >> (N+L) for n < 2^N
   localparam int DIV_L     = $clog2(AVG_PICKS);
   localparam int DIV_SHIFT = SUM_W + DIV_L;
   localparam longint unsigned DIV_NUM   = 64'd1 << DIV_SHIFT;
   localparam longint unsigned DIV_MUL_W = (DIV_NUM + AVG_PICKS - 1) / AVG_PICKS;
   localparam logic [SUM_W:0]     DIV_MUL    = (SUM_W + 1)'(DIV_MUL_W);
   localparam logic [CNT_W-1:0]   PICK_LIMIT = CNT_W'(AVG_PICKS);

   // Entity store: {level sum, running sum, pick count}
   logic [ENTRY_W-1:0] mem [ENT_DEPTH];
   logic [ENT_DEPTH-1:0] vld_ff, vld_in;
   logic [ENTRY_W-1:0] rd_data_ff;

   // Last write, forwarded to the item right behind it
   logic               fwd_vld_ff;
   logic [IDX_W-1:0]   fwd_idx_ff;
   logic [ENTRY_W-1:0] fwd_data_ff;

   // Execute stage
   logic               s2_vld_ff;
   cmd_type            s2_cmd_ff;
   logic [SKIP_W-1:0]  skip_left_ff, skip_left_in;
   logic               scan_active_ff, scan_active_in;

   // Divide stage and output register
   logic               s3_vld_ff;
   logic [SUM_W-1:0]   s3_dividend_ff;
   logic               s3_updated_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   logic               back_en;
   logic               wr_en;
   logic [IDX_W-1:0]   rd_idx;
   logic [IDX_W-1:0]   s2_idx;
   logic [ENTRY_W-1:0] cur_entry;
   logic [SUM_W-1:0]   cur_lvl, cur_acc;
   logic [CNT_W-1:0]   cur_cnt;
   logic [SUM_W-1:0]   new_lvl, new_acc;
   logic [CNT_W-1:0]   new_cnt;
   logic [SUM_W-1:0]   pick_sum;
   logic [CNT_W-1:0]   pick_cnt;
   logic               scan_on;
   logic [SKIP_W-1:0]  skip_now;
   logic               updated;
   logic [PROD_W-1:0]  quot_prod;

   // Whole back end advances unless the output item is held
   assign back_en = !(rsp_valid_ff && rsp_stall);
   assign q_pop   = back_en && q_valid;
   assign rd_idx  = q_data.entity[IDX_W-1:0];
   assign s2_idx  = s2_cmd_ff.entity[IDX_W-1:0];

   // Current entry: forwarded write, stored data, or reset value
   always_comb begin
      if (fwd_vld_ff && fwd_idx_ff == s2_idx) begin
         cur_entry = fwd_data_ff;
      end else if (vld_ff[s2_idx]) begin
         cur_entry = rd_data_ff;
      end else begin
         cur_entry = '0;
      end
   end

   assign cur_lvl  = cur_entry[ENTRY_W-1 -: SUM_W];
   assign cur_acc  = cur_entry[CNT_W +: SUM_W];
   assign cur_cnt  = cur_entry[CNT_W-1:0];
   assign pick_sum = cur_acc + SUM_W'(s2_cmd_ff.mag);
   assign pick_cnt = cur_cnt + CNT_W'(1);
   assign scan_on  = s2_cmd_ff.first || scan_active_ff;
   assign skip_now = s2_cmd_ff.first ? '0 : skip_left_ff;

   // Entity update and scan state
   always_comb begin
      new_lvl        = cur_lvl;
      new_acc        = cur_acc;
      new_cnt        = cur_cnt;
      skip_left_in   = skip_left_ff;
      scan_active_in = scan_active_ff;
      updated        = 1'b0;
      case (s2_cmd_ff.op)
         OP_INIT: begin
            new_lvl = '0;
            new_acc = '0;
            new_cnt = '0;
         end
         OP_CLOSE: begin
            new_lvl = '0;
         end
         OP_SAMPLE: begin
            scan_active_in = scan_on;
            skip_left_in   = skip_now;
            if (scan_on) begin
               if (skip_now == '0) begin
                  skip_left_in = s2_cmd_ff.skip;
                  if (pick_cnt >= PICK_LIMIT) begin
                     // average complete
                     new_lvl        = pick_sum;
                     new_acc        = '0;
                     new_cnt        = '0;
                     scan_active_in = 1'b0;
                     updated        = 1'b1;
                  end else begin
                     new_acc = pick_sum;
                     new_cnt = pick_cnt;
                  end
               end else begin
                  skip_left_in = skip_now - 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign wr_en = back_en && s2_vld_ff && (s2_cmd_ff.op inside {OP_SAMPLE, OP_INIT, OP_CLOSE});

   // Valid bits: entry reads as zero until first written
   always_comb begin
      vld_in = vld_ff;
      if (wr_en) begin
         vld_in[s2_idx] = 1'b1;
      end
   end

   // Entity memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[s2_idx] <= {new_lvl, new_acc, new_cnt};
      end
      if (back_en) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff         <= '0;
         fwd_vld_ff     <= 1'b0;
         s2_vld_ff      <= 1'b0;
         s3_vld_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         skip_left_ff   <= '0;
         scan_active_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
         if (wr_en) begin
            fwd_vld_ff <= 1'b1;
         end
         if (back_en) begin
            s2_vld_ff    <= q_valid;
            s3_vld_ff    <= s2_vld_ff;
            rsp_valid_ff <= s3_vld_ff;
            if (s2_vld_ff) begin
               skip_left_ff   <= skip_left_in;
               scan_active_ff <= scan_active_in;
            end
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (wr_en) begin
         fwd_idx_ff  <= s2_idx;
         fwd_data_ff <= {new_lvl, new_acc, new_cnt};
      end
      if (back_en) begin
         s2_cmd_ff      <= q_data;
         s3_dividend_ff <= (s2_cmd_ff.op == OP_IGNORE) ? '0 : new_lvl;
         s3_updated_ff  <= updated;
         rsp_data_ff.mouth_level   <= quot_prod[DIV_SHIFT +: LEVEL_W];
         rsp_data_ff.level_updated <= s3_updated_ff;
      end
   end

   // Divide by AVG_PICKS through the reciprocal multiply
   assign quot_prod = {{(SUM_W + 1){1'b0}}, s3_dividend_ff} * {{SUM_W{1'b0}}, DIV_MUL};

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* rtl/audio_level_envelope_sampler_top.sv */
// Audio level envelope sampler, top level. Depends on ales_pkg, ales_front,
// ales_queue and ales_back.
// An accepted item reaches its result through the queue slot, execute, divide
// and output registers; one item per cycle while the output is not stalled.
// Throughput is set by the per-entity read-modify-write memory, kept at one
// item per cycle by forwarding the last write. Synchronous reset clears the
// format register, scan state, queue and all entity valid bits.
module audio_level_envelope_sampler_top #(
   parameter int AVG_PICKS    = 10,
   parameter int ENTITY_COUNT = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  ales_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output ales_pkg::rsp_type           rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [ales_pkg::FMT_W-1:0]  csr_data
);
   import ales_pkg::*;

   logic [FMT_W-1:0] sample_format_ff;
   logic             q_push;
   logic             q_full;
   logic             q_pop;
   logic             q_valid;
   cmd_type          q_cmd;
   cmd_type          q_head;

   // Format register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_format_ff <= FMT_U8;
      end else if (csr_valid && csr_ready) begin
         sample_format_ff <= csr_data;
      end
   end

   assign req_stall = q_full;

   ales_front #(
      .ENTITY_COUNT (ENTITY_COUNT)
   ) u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .sample_format (sample_format_ff),
      .q_push        (q_push),
      .q_cmd         (q_cmd)
   );

   ales_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (q_head)
   );

   ales_back #(
      .AVG_PICKS    (AVG_PICKS),
      .ENTITY_COUNT (ENTITY_COUNT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // An accepted item is queued for the back end
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> q_valid)
      else $error("accepted item missing from command queue");

   // A held output item freezes the back end
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !q_pop)
      else $error("queue popped while output item held");

   // No result item right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule
